/* rtl/lfp_pkg.sv */
// Shared types and constants of the line-follow PID lap counter.
package lfp_pkg;

  localparam int unsigned SENS_W      = 5;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned BASE_W      = 7;
  localparam int unsigned ILIM_W      = 15;
  localparam int unsigned LAP_W       = 8;
  localparam int unsigned HOLD_W      = 8;
  localparam int unsigned DRIVE_W     = 8;
  localparam int unsigned ISUM_W      = 16;
  localparam int unsigned MUL_B_W     = 16;
  localparam int unsigned PROD_W      = GAIN_W + 1 + MUL_B_W;
  localparam int unsigned ACC_W       = PROD_W + 2;
  localparam int unsigned CORR_MAG_W  = 8;
  localparam int unsigned CORR_W      = CORR_MAG_W + 1;
  localparam int unsigned SUMV_W      = CORR_W + 1;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam logic [SENS_W-1:0] SENS_ALL = 5'h1F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN        = 3'd0,
    CFG_KI_GAIN        = 3'd1,
    CFG_KD_GAIN        = 3'd2,
    CFG_BASE_DRIVE     = 3'd3,
    CFG_DRIVE_LIMIT    = 3'd4,
    CFG_INTEGRAL_LIMIT = 3'd5,
    CFG_TARGET_LAPS    = 3'd6,
    CFG_CORNER_HOLDOFF = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEL_P = 2'd0,
    SEL_I = 2'd1,
    SEL_D = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     zero;
    logic     hold;
    logic     div_start;
    logic     div_step;
    logic     pid_upd;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     corr;
    logic     drive;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic holdoff_nz;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/lfp_ctrl.sv */
// Sequencer of the line-follow PID lap counter.
module lfp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lfp_pkg::sts_t sts_i,
  output lfp_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHECK = 11'b000_0000_0010,
    S_DIV   = 11'b000_0000_0100,
    S_PID   = 11'b000_0000_1000,
    S_MUL_P = 11'b000_0001_0000,
    S_MUL_I = 11'b000_0010_0000,
    S_MUL_D = 11'b000_0100_0000,
    S_ACC   = 11'b000_1000_0000,
    S_CORR  = 11'b001_0000_0000,
    S_DRIVE = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts_i.finished) begin
          cmd_o.zero = 1'b1;
          state_d    = S_OUT;
        end else if (sts_i.holdoff_nz) begin
          cmd_o.hold = 1'b1;
          state_d    = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_PID;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_PID: begin
        cmd_o.pid_upd = 1'b1;
        state_d       = S_MUL_P;
      end
      S_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lfp_pkg::SEL_P;
        state_d       = S_MUL_I;
      end
      S_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lfp_pkg::SEL_I;
        cmd_o.acc_add = 1'b1;
        cmd_o.acc_clr = 1'b1;
        state_d       = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lfp_pkg::SEL_D;
        cmd_o.acc_add = 1'b1;
        state_d       = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_CORR;
      end
      S_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = S_DRIVE;
      end
      S_DRIVE: begin
        cmd_o.drive = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/lfp_dp.sv */
// Datapath of the line-follow PID lap counter: registers, divider, MAC, drive logic.
module lfp_dp #(
  parameter int unsigned ERROR_FRAC_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [lfp_pkg::SENS_W-1:0]         sens_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [lfp_pkg::OUT_TDATA_W-1:0]    out_data_o,
  input  lfp_pkg::cmd_t                      cmd_i,
  output lfp_pkg::sts_t                      sts_o
);

  localparam int unsigned F     = ERROR_FRAC_BITS;
  localparam int unsigned EW    = F + 3;
  localparam int unsigned DW    = F + 4;
  localparam int unsigned NW    = F + 2;
  localparam int unsigned CW    = $clog2(NW + 1);
  localparam int unsigned SHIFT = 8 + F;
  localparam int unsigned PADW  = lfp_pkg::OUT_TDATA_W - 3 * lfp_pkg::DRIVE_W - 2;

  // configuration
  logic [lfp_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [lfp_pkg::BASE_W-1:0] base_q, dlim_q;
  logic [lfp_pkg::ILIM_W-1:0] ilim_q;
  logic [lfp_pkg::LAP_W-1:0]  target_q;
  logic [lfp_pkg::HOLD_W-1:0] chold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= 16'd6400;
      ki_q     <= 16'd26;
      kd_q     <= 16'd3840;
      base_q   <= 7'd60;
      dlim_q   <= 7'd90;
      ilim_q   <= 15'd25600;
      target_q <= 8'd1;
      chold_q  <= 8'd50;
    end else if (cfg_we_i) begin
      unique case (lfp_pkg::cfg_idx_e'(cfg_idx_i))
        lfp_pkg::CFG_KP_GAIN:        kp_q     <= cfg_data_i;
        lfp_pkg::CFG_KI_GAIN:        ki_q     <= cfg_data_i;
        lfp_pkg::CFG_KD_GAIN:        kd_q     <= cfg_data_i;
        lfp_pkg::CFG_BASE_DRIVE:     base_q   <= cfg_data_i[lfp_pkg::BASE_W-1:0];
        lfp_pkg::CFG_DRIVE_LIMIT:    dlim_q   <= cfg_data_i[lfp_pkg::BASE_W-1:0];
        lfp_pkg::CFG_INTEGRAL_LIMIT: ilim_q   <= cfg_data_i[lfp_pkg::ILIM_W-1:0];
        lfp_pkg::CFG_TARGET_LAPS:    target_q <= cfg_data_i[lfp_pkg::LAP_W-1:0];
        lfp_pkg::CFG_CORNER_HOLDOFF: chold_q  <= cfg_data_i[lfp_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // sensor decode: weight +2 at bit 0 down to -2 at bit 4
  logic [lfp_pkg::SENS_W-1:0] sens_q;
  logic signed [3:0]          w_sum;
  logic [2:0]                 w_cnt;
  logic [1:0]                 w_mag;

  always_comb begin
    w_sum = '0;
    w_cnt = '0;
    for (int k = 0; k < lfp_pkg::SENS_W; k++) begin
      if (sens_q[k]) begin
        w_sum = w_sum + $signed(4'(2 - k));
        w_cnt = w_cnt + 3'd1;
      end
    end
    w_mag = w_sum[3] ? 2'(-w_sum) : w_sum[1:0];
  end

  // restoring divider, one quotient bit per step
  logic [NW-1:0] div_n_q, div_quo_q;
  logic [2:0]    div_r_q, div_c_q;
  logic [CW-1:0] div_cnt_q;
  logic          neg_q, zero_q;
  logic [3:0]    rem_sh;
  logic          rem_ge;

  assign rem_sh = {div_r_q, div_n_q[NW-1]};
  assign rem_ge = rem_sh >= {1'b0, div_c_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_n_q   <= {w_mag, {F{1'b0}}};
      div_r_q   <= '0;
      div_quo_q <= '0;
      div_c_q   <= w_cnt;
      div_cnt_q <= CW'(NW);
      neg_q     <= w_sum[3];
      zero_q    <= (w_cnt == 3'd0);
    end else if (cmd_i.div_step) begin
      div_n_q   <= div_n_q << 1;
      div_r_q   <= rem_ge ? 3'(rem_sh - {1'b0, div_c_q}) : rem_sh[2:0];
      div_quo_q <= {div_quo_q[NW-2:0], rem_ge};
      div_cnt_q <= div_cnt_q - CW'(1);
    end
  end

  logic signed [EW-1:0] e_w;
  logic [EW-1:0]        e_mag;

  assign e_mag = zero_q ? '0 : {1'b0, div_quo_q};
  assign e_w   = neg_q ? -$signed(e_mag) : $signed(e_mag);

  // PID state
  logic signed [lfp_pkg::ISUM_W-1:0] esum_q;
  logic signed [EW-1:0]              last_e_q, e_q;
  logic signed [DW-1:0]              d_q;
  logic signed [lfp_pkg::ISUM_W:0]   sum_w, lim_w, sum_sat;

  assign sum_w = (lfp_pkg::ISUM_W + 1)'(esum_q) + (lfp_pkg::ISUM_W + 1)'(e_w);
  assign lim_w = $signed({2'b00, ilim_q});

  always_comb begin
    priority if (sum_w > lim_w) begin
      sum_sat = lim_w;
    end else if (sum_w < -lim_w) begin
      sum_sat = -lim_w;
    end else begin
      sum_sat = sum_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q   <= '0;
      last_e_q <= '0;
    end else if (cmd_i.pid_upd) begin
      esum_q   <= lfp_pkg::ISUM_W'(sum_sat);
      last_e_q <= e_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pid_upd) begin
      e_q <= e_w;
      d_q <= DW'(e_w) - DW'(last_e_q);
    end
  end

  // shared multiplier and accumulator
  logic [lfp_pkg::GAIN_W-1:0]         mul_gain;
  logic signed [lfp_pkg::MUL_B_W-1:0] mul_b;
  logic signed [lfp_pkg::PROD_W-1:0]  prod_q;
  logic signed [lfp_pkg::ACC_W-1:0]   acc_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      lfp_pkg::SEL_P: begin
        mul_gain = kp_q;
        mul_b    = lfp_pkg::MUL_B_W'(e_q);
      end
      lfp_pkg::SEL_I: begin
        mul_gain = ki_q;
        mul_b    = lfp_pkg::MUL_B_W'(esum_q);
      end
      lfp_pkg::SEL_D: begin
        mul_gain = kd_q;
        mul_b    = lfp_pkg::MUL_B_W'(d_q);
      end
      default: begin
        mul_gain = '0;
        mul_b    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= $signed({1'b0, mul_gain}) * mul_b;
    end
    if (cmd_i.acc_add) begin
      acc_q <= (cmd_i.acc_clr ? '0 : acc_q) + lfp_pkg::ACC_W'(prod_q);
    end
  end

  // correction: truncate toward zero, clamp magnitude (drives saturate anyway)
  logic [lfp_pkg::ACC_W-1:0]      acc_abs, acc_shr;
  logic [lfp_pkg::CORR_MAG_W-1:0] corr_mag;
  logic signed [lfp_pkg::CORR_W-1:0] corr_q;

  assign acc_abs  = acc_q[lfp_pkg::ACC_W-1] ? lfp_pkg::ACC_W'(-acc_q)
                                             : lfp_pkg::ACC_W'(acc_q);
  assign acc_shr  = acc_abs >> SHIFT;
  assign corr_mag = (acc_shr > lfp_pkg::ACC_W'({lfp_pkg::CORR_MAG_W{1'b1}}))
                    ? {lfp_pkg::CORR_MAG_W{1'b1}} : acc_shr[lfp_pkg::CORR_MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.corr) begin
      corr_q <= acc_q[lfp_pkg::ACC_W-1] ? -$signed({1'b0, corr_mag})
                                         : $signed({1'b0, corr_mag});
    end
  end

  function automatic logic signed [lfp_pkg::DRIVE_W-1:0] sat_drive(
    input logic signed [lfp_pkg::SUMV_W-1:0] v,
    input logic [lfp_pkg::BASE_W-1:0]        lim
  );
    logic signed [lfp_pkg::SUMV_W-1:0] l;
    logic signed [lfp_pkg::SUMV_W-1:0] r;
    l = $signed({3'b000, lim});
    priority if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r[lfp_pkg::DRIVE_W-1:0];
  endfunction

  logic signed [lfp_pkg::SUMV_W-1:0]  base_w;
  logic signed [lfp_pkg::DRIVE_W-1:0] left_w, right_w;

  assign base_w  = $signed({3'b000, base_q});
  assign left_w  = sat_drive(base_w - lfp_pkg::SUMV_W'(corr_q), dlim_q);
  assign right_w = sat_drive(base_w + lfp_pkg::SUMV_W'(corr_q), dlim_q);

  // run state
  logic [1:0]                  phase_q;
  logic [lfp_pkg::LAP_W-1:0]   laps_q, laps_inc;
  logic [lfp_pkg::HOLD_W-1:0]  hold_q;
  logic                        fin_q;
  logic [lfp_pkg::DRIVE_W-1:0] held_l_q, held_r_q;
  logic [lfp_pkg::DRIVE_W-1:0] res_l_q, res_r_q;
  logic                        res_corner_q;

  assign laps_inc = laps_q + lfp_pkg::LAP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      laps_q   <= '0;
      hold_q   <= '0;
      fin_q    <= 1'b0;
      held_l_q <= '0;
      held_r_q <= '0;
    end else begin
      if (cmd_i.load && (laps_q >= target_q)) begin
        fin_q <= 1'b1;
      end
      if (cmd_i.hold) begin
        hold_q <= hold_q - lfp_pkg::HOLD_W'(1);
      end
      if (cmd_i.drive) begin
        held_l_q <= left_w;
        held_r_q <= right_w;
        if (sens_q == lfp_pkg::SENS_ALL) begin
          phase_q <= phase_q + 2'd1;
          hold_q  <= chold_q;
          if (phase_q == 2'd3) begin
            laps_q <= laps_inc;
            if (laps_inc >= target_q) begin
              fin_q <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sens_q <= sens_i;
    end
    if (cmd_i.zero) begin
      res_l_q      <= '0;
      res_r_q      <= '0;
      res_corner_q <= 1'b0;
    end else if (cmd_i.hold) begin
      res_l_q      <= held_l_q;
      res_r_q      <= held_r_q;
      res_corner_q <= 1'b0;
    end else if (cmd_i.drive) begin
      // a lap that meets the target stops the wheels on this very tick
      if ((sens_q == lfp_pkg::SENS_ALL) && (phase_q == 2'd3) && (laps_inc >= target_q)) begin
        res_l_q      <= '0;
        res_r_q      <= '0;
        res_corner_q <= 1'b0;
      end else begin
        res_l_q      <= left_w;
        res_r_q      <= right_w;
        res_corner_q <= (sens_q == lfp_pkg::SENS_ALL);
      end
    end
  end

  // output register
  logic                            out_valid_q;
  logic [lfp_pkg::OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {{PADW{1'b0}}, fin_q, res_corner_q, laps_q, res_r_q, res_l_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.finished   = fin_q;
  assign sts_o.holdoff_nz = (hold_q != '0);
  assign sts_o.div_done   = (div_cnt_q == '0);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

/* rtl/line_follow_pid_lap_counter.sv */
// Top level of the line-follow PID lap counter: sequencer plus datapath.
// A PID tick passes from input transfer to tvalid through the bit-serial position divider
// and one shared 17x16 multiplier used three times; holdoff and finished ticks skip both.
// One tick is in flight at a time: the next input is taken only once the previous result
// has been emitted, and it can be taken while that result waits in the output reg.
// Reset (async, active low) clears the PID, lap and holdoff state and loads defaults.
module line_follow_pid_lap_counter #(
  parameter int unsigned ERROR_FRAC_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // sensor stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lfp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [4:0] line_sensors
  // drive stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] left_drive, [15:8] right_drive, [23:16] lap_count,
  // [24] corner_seen, [25] run_done
  output logic [lfp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  lfp_pkg::cmd_t cmd;
  lfp_pkg::sts_t sts;

  // Sequencer: accepts a tick in idle and checks it; a PID tick then steps the datapath
  // through divide, PID update, three multiplies, accumulate, correction and drive.
  lfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: holds configuration, PID and lap state, and the output register.
  lfp_dp #(
    .ERROR_FRAC_BITS (ERROR_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sens_i      (s_axis_tdata[lfp_pkg::SENS_W-1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTHESIS
  // A finished run shows stopped wheels and no corner.
  a_done_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[25] |-> (m_axis_tdata[15:0] == 16'h0) && !m_axis_tdata[24])
    else $error("run_done result carries nonzero drive or corner");

  // One tick in flight: ready drops right after an input transfer.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a tick is in progress");
`endif

endmodule
